FILE: hw/rtl/fem_tgs_pkg.sv
// Shared types and constants for the triangle gradient sensitivity core.
package fem_tgs_pkg;

  localparam int NODE_COUNT_DEF  = 1024;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int ACC_WIDTH_DEF   = 64;

  localparam int IDX_W     = 10;
  localparam int FIELD_W   = 32;
  localparam int OUT_SUM_W = 64;
  localparam int S_TDATA_W = 232;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 144;

  // bits of the multiplier operand consumed per cycle
  localparam int MUL_DIGIT = 8;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_ELEM = 2'd1,
    OP_READ = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_NODE_RD,
    ST_NODE_CAP,
    ST_PREP,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_READ_WAIT,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_DET,
    PH_DOT,
    PH_NUM
  } phase_t;

endpackage

FILE: hw/rtl/fem_triangle_gradient_sensitivity_core.sv
// Triangle gradient sensitivity core: node store, element sequencer and accumulators.
//
// A request carries an op in s_tuser: load writes one node's coordinates and complex
// direct/adjoint values, element sorts its three vertices, forms the linear-triangle
// gradient-gradient weights and adds the same complex sum, divided by 6|D| with
// truncation and saturated, to all three vertices' accumulators; read returns a node's
// sums. Every request yields exactly one result. After reset the core sweeps the
// accumulator memory to zero and takes no request until that pass ends. In an element
// the 34 products go one after another through the shared digit-serial multiplier and
// the two quotients through the bit-serial divider. One request is in work at a time; a
// finished result sits in the output register, so the next request is taken while it
// waits. A degenerate element (zero determinant, repeated vertex or a vertex index of
// NODE_COUNT or more) is skipped with status 1.
module fem_triangle_gradient_sensitivity_core #(
  parameter int NODE_COUNT  = fem_tgs_pkg::NODE_COUNT_DEF,
  parameter int VALUE_WIDTH = fem_tgs_pkg::VALUE_WIDTH_DEF,
  parameter int ACC_WIDTH   = fem_tgs_pkg::ACC_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // node_index, coord_x, coord_y, direct_re, direct_im, adjoint_re, adjoint_im,
  // vertex_a, vertex_b, vertex_c
  input  logic [fem_tgs_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic [fem_tgs_pkg::S_TUSER_W-1:0] s_tuser,  // op
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // result_node, sum_re, sum_im, zero pad
  output logic [fem_tgs_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                              m_tuser   // status
);
  import fem_tgs_pkg::*;

  localparam int AW     = $clog2(NODE_COUNT);
  localparam int VW     = VALUE_WIDTH;
  localparam int DW     = VW + 1;          // coordinate differences
  localparam int MW     = 2 * VW + 3;      // determinant and dot sums
  localparam int PW     = 2 * MW;
  localparam int NW     = PW + 2;          // numerators
  localparam int DENW   = MW + 3;          // 6 * |D|
  localparam int NODE_W = 6 * VW;
  localparam int ACCM_W = 2 * ACC_WIDTH;
  localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
  localparam logic [ACC_WIDTH-1:0] ACC_MAX = ~ACC_MIN;

  // control
  state_t        state, state_next;
  phase_t        phase;
  logic [1:0]    sub;
  logic [2:0]    grp;
  logic          div_sel;
  logic [AW-1:0] clr_addr;

  // latched request
  op_t               req_op;
  logic [IDX_W-1:0]  req_node;
  logic [NODE_W-1:0] req_vals;
  logic [IDX_W-1:0]  req_va, req_vb, req_vc;

  // element datapath
  logic [IDX_W-1:0]      vs [3];
  logic signed [VW-1:0]  x [3], y [3], dr [3], di [3], ar [3], ai [3];
  logic signed [DW-1:0]  px [3], py [3];
  logic signed [DW-1:0]  ex, ey1, ex2, ey2;
  logic signed [MW-1:0]  d, d_next, dacc, dacc_next;
  logic [MW-1:0]         dabs;
  logic [DENW-1:0]       den, den_next;
  logic signed [MW-1:0]  dot [8];
  logic signed [NW-1:0]  nr, ni, term;
  logic signed [ACC_WIDTH-1:0] sr, si;

  // result and output registers
  logic [IDX_W-1:0]     res_node, out_node;
  logic [ACC_WIDTH-1:0] res_re, res_im, out_re, out_im;
  logic                 res_status, out_status;

  // sorting and range checks
  logic [IDX_W-1:0] srt0, srt1, srt2, tmp_v;
  logic             node_ok, elem_ok;

  // memories and arithmetic units
  logic                node_we;
  logic [AW-1:0]       node_raddr;
  logic [NODE_W-1:0]   node_rdata;
  logic                acc_we;
  logic [AW-1:0]       acc_waddr, acc_raddr;
  logic [ACCM_W-1:0]   acc_wdata, acc_rdata;
  logic                mul_start, mul_done, div_start, div_done;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;
  logic signed [NW-1:0] div_num;
  logic signed [ACC_WIDTH-1:0] div_q;
  logic [ACC_WIDTH-1:0] cur_re, cur_im, new_re, new_im;
  logic [ACC_WIDTH:0]   sum_re_w, sum_im_w;

  assign s_tready = (state == ST_IDLE);
  assign m_tuser  = out_status;
  assign m_tdata  = M_TDATA_W'({OUT_SUM_W'(signed'(out_im)), OUT_SUM_W'(signed'(out_re)),
                                out_node});

  // Sort the vertex numbers ascending.
  always_comb begin
    srt0  = req_va;
    srt1  = req_vb;
    srt2  = req_vc;
    tmp_v = '0;
    if (srt0 > srt1) begin
      tmp_v = srt0; srt0 = srt1; srt1 = tmp_v;
    end
    if (srt1 > srt2) begin
      tmp_v = srt1; srt1 = srt2; srt2 = tmp_v;
    end
    if (srt0 > srt1) begin
      tmp_v = srt0; srt0 = srt1; srt1 = tmp_v;
    end
  end

  assign node_ok = 32'(req_node) < 32'(NODE_COUNT);
  assign elem_ok = 32'(srt2) < 32'(NODE_COUNT);

  // Arithmetic around the shared units.
  assign d_next    = d - MW'(mul_p);
  assign dacc_next = dacc + MW'(mul_p);
  assign term      = NW'(mul_p);
  assign dabs      = d_next[MW-1] ? MW'(-d_next) : MW'(d_next);
  assign den_next  = (DENW'(dabs) << 2) + (DENW'(dabs) << 1);
  assign div_num   = div_sel ? ni : nr;

  // Saturating add of the element sum into the fetched accumulator.
  assign cur_re   = acc_rdata[ACC_WIDTH-1:0];
  assign cur_im   = acc_rdata[ACCM_W-1:ACC_WIDTH];
  assign sum_re_w = {cur_re[ACC_WIDTH-1], cur_re} + {sr[ACC_WIDTH-1], sr};
  assign sum_im_w = {cur_im[ACC_WIDTH-1], cur_im} + {si[ACC_WIDTH-1], si};
  assign new_re   = (sum_re_w[ACC_WIDTH] != sum_re_w[ACC_WIDTH-1]) ?
                    (sum_re_w[ACC_WIDTH] ? ACC_MIN : ACC_MAX) : sum_re_w[ACC_WIDTH-1:0];
  assign new_im   = (sum_im_w[ACC_WIDTH] != sum_im_w[ACC_WIDTH-1]) ?
                    (sum_im_w[ACC_WIDTH] ? ACC_MIN : ACC_MAX) : sum_im_w[ACC_WIDTH-1:0];

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(NODE_COUNT - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        unique case (req_op)
          OP_LOAD: state_next = ST_DONE;
          OP_READ: state_next = node_ok ? ST_READ_WAIT : ST_DONE;
          OP_ELEM: state_next = elem_ok ? ST_NODE_RD : ST_DONE;
          default: state_next = ST_DONE;
        endcase
      end
      ST_NODE_RD:   state_next = ST_NODE_CAP;
      ST_NODE_CAP:  state_next = (sub == 2'd2) ? ST_PREP : ST_NODE_RD;
      ST_PREP:      state_next = ST_MUL_GO;
      ST_MUL_GO:    state_next = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (mul_done) begin
          unique case (phase)
            PH_DET: begin
              if (sub != 2'd0 && d_next == '0) state_next = ST_DONE;
              else state_next = ST_MUL_GO;
            end
            PH_DOT: state_next = ST_MUL_GO;
            PH_NUM: state_next = (grp == 3'd7) ? ST_DIV_GO : ST_MUL_GO;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_DIV_GO:    state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) state_next = div_sel ? ST_ACC_RD : ST_DIV_GO;
      end
      ST_ACC_RD:    state_next = ST_ACC_WR;
      ST_ACC_WR:    state_next = (sub == 2'd2) ? ST_DONE : ST_ACC_RD;
      ST_READ_WAIT: state_next = ST_DONE;
      ST_DONE: begin
        if (!m_tvalid || m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory strobes and operand selection.
  always_comb begin
    node_we    = (state == ST_DISPATCH) && (req_op == OP_LOAD) && node_ok;
    node_raddr = AW'(vs[sub]);
    acc_we     = (state == ST_CLEAR) || (state == ST_ACC_WR);
    acc_waddr  = (state == ST_CLEAR) ? clr_addr : AW'(vs[sub]);
    acc_wdata  = (state == ST_CLEAR) ? '0 : {new_im, new_re};
    acc_raddr  = (state == ST_ACC_RD) ? AW'(vs[sub]) : AW'(req_node);
    mul_start  = (state == ST_MUL_GO);
    div_start  = (state == ST_DIV_GO);
    mul_a      = '0;
    mul_b      = '0;
    unique case (phase)
      PH_DET: begin
        mul_a = (sub == 2'd0) ? MW'(ex) : MW'(ey1);
        mul_b = (sub == 2'd0) ? MW'(ey2) : MW'(ex2);
      end
      PH_DOT: begin
        mul_a = grp[1] ? MW'(py[sub]) : MW'(px[sub]);
        unique case ({grp[2], grp[0]})
          2'b00:   mul_b = MW'(dr[sub]);
          2'b01:   mul_b = MW'(di[sub]);
          2'b10:   mul_b = MW'(ar[sub]);
          default: mul_b = MW'(ai[sub]);
        endcase
      end
      PH_NUM: begin
        // real: uxr*vxr - uxi*vxi + uyr*vyr - uyi*vyi; imag: cross terms
        unique case (grp)
          3'd0: begin mul_a = dot[0]; mul_b = dot[4]; end
          3'd1: begin mul_a = dot[1]; mul_b = dot[5]; end
          3'd2: begin mul_a = dot[2]; mul_b = dot[6]; end
          3'd3: begin mul_a = dot[3]; mul_b = dot[7]; end
          3'd4: begin mul_a = dot[0]; mul_b = dot[5]; end
          3'd5: begin mul_a = dot[1]; mul_b = dot[4]; end
          3'd6: begin mul_a = dot[2]; mul_b = dot[7]; end
          default: begin mul_a = dot[3]; mul_b = dot[6]; end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      phase    <= PH_DET;
      sub      <= '0;
      grp      <= '0;
      div_sel  <= 1'b0;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (state == ST_DONE && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_DISPATCH: sub <= '0;
        ST_NODE_CAP: sub <= (sub == 2'd2) ? 2'd0 : sub + 1'b1;
        ST_PREP: begin
          phase   <= PH_DET;
          sub     <= '0;
          grp     <= '0;
          div_sel <= 1'b0;
        end
        ST_MUL_WAIT: begin
          if (mul_done) begin
            unique case (phase)
              PH_DET: begin
                if (sub == 2'd0) begin
                  sub <= 2'd1;
                end else begin
                  sub   <= '0;
                  phase <= PH_DOT;
                end
              end
              PH_DOT: begin
                if (sub == 2'd2) begin
                  sub <= '0;
                  grp <= grp + 1'b1;
                  if (grp == 3'd7) phase <= PH_NUM;
                end else begin
                  sub <= sub + 1'b1;
                end
              end
              default: grp <= grp + 1'b1;
            endcase
          end
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            div_sel <= 1'b1;
            sub     <= '0;
          end
        end
        ST_ACC_WR: sub <= (sub == 2'd2) ? 2'd0 : sub + 1'b1;
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      req_op   <= op_t'(s_tuser);
      req_node <= s_tdata[IDX_W-1:0];
      for (int i = 0; i < 6; i++) begin
        req_vals[i*VW +: VW] <= s_tdata[IDX_W + i*FIELD_W +: VW];
      end
      req_va <= s_tdata[IDX_W + 6*FIELD_W +: IDX_W];
      req_vb <= s_tdata[2*IDX_W + 6*FIELD_W +: IDX_W];
      req_vc <= s_tdata[3*IDX_W + 6*FIELD_W +: IDX_W];
    end
    unique case (state)
      ST_DISPATCH: begin
        res_node   <= (req_op == OP_LOAD || req_op == OP_READ) ? req_node : '0;
        res_re     <= '0;
        res_im     <= '0;
        res_status <= (req_op == OP_ELEM) && !elem_ok;
        vs[0] <= srt0;
        vs[1] <= srt1;
        vs[2] <= srt2;
      end
      ST_READ_WAIT: begin
        res_re <= cur_re;
        res_im <= cur_im;
      end
      ST_NODE_CAP: begin
        x[sub]  <= node_rdata[0*VW +: VW];
        y[sub]  <= node_rdata[1*VW +: VW];
        dr[sub] <= node_rdata[2*VW +: VW];
        di[sub] <= node_rdata[3*VW +: VW];
        ar[sub] <= node_rdata[4*VW +: VW];
        ai[sub] <= node_rdata[5*VW +: VW];
      end
      ST_PREP: begin
        px[0] <= DW'(y[1]) - DW'(y[2]);
        py[0] <= DW'(x[2]) - DW'(x[1]);
        px[1] <= DW'(y[2]) - DW'(y[0]);
        py[1] <= DW'(x[0]) - DW'(x[2]);
        px[2] <= DW'(y[0]) - DW'(y[1]);
        py[2] <= DW'(x[1]) - DW'(x[0]);
        ex    <= DW'(x[1]) - DW'(x[0]);
        ey2   <= DW'(y[2]) - DW'(y[0]);
        ey1   <= DW'(y[1]) - DW'(y[0]);
        ex2   <= DW'(x[2]) - DW'(x[0]);
        dacc  <= '0;
        nr    <= '0;
        ni    <= '0;
      end
      ST_MUL_WAIT: begin
        if (mul_done) begin
          unique case (phase)
            PH_DET: begin
              if (sub == 2'd0) begin
                d <= MW'(mul_p);
              end else begin
                d   <= d_next;
                den <= den_next;
                if (d_next == '0) res_status <= 1'b1;
              end
            end
            PH_DOT: begin
              if (sub == 2'd2) begin
                dot[grp] <= dacc_next;
                dacc     <= '0;
              end else begin
                dacc <= dacc_next;
              end
            end
            default: begin
              if (!grp[2]) nr <= grp[0] ? nr - term : nr + term;
              else ni <= ni + term;
            end
          endcase
        end
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (div_sel) si <= div_q;
          else sr <= div_q;
        end
      end
      default: ;
    endcase
    if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      out_node   <= res_node;
      out_re     <= res_re;
      out_im     <= res_im;
      out_status <= res_status;
    end
  end

  // Node store: {adjoint_im, adjoint_re, direct_im, direct_re, y, x}.
  fem_tgs_ram #(
    .DEPTH (NODE_COUNT),
    .WIDTH (NODE_W)
  ) u_node_mem (
    .clk   (clk),
    .we    (node_we),
    .waddr (AW'(req_node)),
    .wdata (req_vals),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  // Accumulator store: {im, re}.
  fem_tgs_ram #(
    .DEPTH (NODE_COUNT),
    .WIDTH (ACCM_W)
  ) u_acc_mem (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  fem_tgs_mul #(
    .MW (MW)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  fem_tgs_div #(
    .NW        (NW),
    .DENW      (DENW),
    .ACC_WIDTH (ACC_WIDTH)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (den),
    .done  (div_done),
    .q     (div_q)
  );

  // A request in work blocks the next one.
  a_single_request: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while another is in work");

  // Division only runs on a nonzero determinant.
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_GO) |-> (den != '0))
    else $error("division started with zero denominator");

  // Accumulated vertices are distinct and sorted.
  a_vertices_sorted: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACC_RD) |-> ((vs[0] < vs[1]) && (vs[1] < vs[2])))
    else $error("accumulating to unsorted or repeated vertices");

endmodule

FILE: hw/rtl/fem_tgs_ram.sv
// Single-port-write, single-port-read synchronous memory with registered read data.
module fem_tgs_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/fem_tgs_mul.sv
// Iterative signed multiplier, one digit of the second operand per cycle.
module fem_tgs_mul #(
  parameter int MW = 67
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [MW-1:0]   a,
  input  logic signed [MW-1:0]   b,
  output logic                   done,
  output logic signed [2*MW-1:0] p
);
  import fem_tgs_pkg::*;

  localparam int PW    = 2 * MW;
  localparam int STEPS = (MW + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int BW    = STEPS * MUL_DIGIT;
  localparam int CW    = $clog2(STEPS + 1);

  logic                      busy;
  logic                      fin;
  logic                      neg;
  logic [CW-1:0]             cnt;
  logic [MW-1:0]             amag;
  logic [BW-1:0]             bsh;
  logic [PW-1:0]             acc;
  logic [MW+MUL_DIGIT-1:0]   part;

  assign part = amag * bsh[BW-1 -: MUL_DIGIT];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(STEPS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= a[MW-1] ^ b[MW-1];
      amag <= a[MW-1] ? MW'(-a) : MW'(a);
      bsh  <= BW'(b[MW-1] ? MW'(-b) : MW'(b));
      acc  <= '0;
    end else if (busy) begin
      // shift in the next digit, most significant first
      acc <= (acc << MUL_DIGIT) + PW'(part);
      bsh <= bsh << MUL_DIGIT;
    end
    if (fin) begin
      p <= neg ? -signed'(acc) : signed'(acc);
    end
  end

endmodule

FILE: hw/rtl/fem_tgs_div.sv
// Restoring divider, one quotient bit per cycle, with signed saturating result.
module fem_tgs_div #(
  parameter int NW        = 136,
  parameter int DENW      = 70,
  parameter int ACC_WIDTH = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [NW-1:0]        num,
  input  logic [DENW-1:0]             den,
  output logic                        done,
  output logic signed [ACC_WIDTH-1:0] q
);

  localparam int CW = $clog2(NW + 1);
  localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
  localparam logic [ACC_WIDTH-1:0] ACC_MAX = ~ACC_MIN;

  logic            busy;
  logic            fin;
  logic            neg;
  logic [CW-1:0]   cnt;
  logic [NW-1:0]   nq;
  logic [DENW-1:0] rem;
  logic [DENW:0]   trial;
  logic [DENW:0]   diff;
  logic            fits;
  logic            big;

  assign trial = {rem, nq[NW-1]};
  assign diff  = trial - {1'b0, den};
  assign fits  = trial >= {1'b0, den};
  assign big   = |(nq >> (ACC_WIDTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[NW-1];
      nq  <= num[NW-1] ? NW'(-num) : NW'(num);
      rem <= '0;
    end else if (busy) begin
      // dividend bits leave at the top, quotient bits enter at the bottom
      rem <= fits ? diff[DENW-1:0] : trial[DENW-1:0];
      nq  <= {nq[NW-2:0], fits};
    end
    if (fin) begin
      if (big) begin
        q <= neg ? ACC_MIN : ACC_MAX;
      end else begin
        q <= neg ? -signed'(nq[ACC_WIDTH-1:0]) : signed'(nq[ACC_WIDTH-1:0]);
      end
    end
  end

endmodule

FILE: dv/tb_fem_triangle_gradient_sensitivity_core.sv
// Testbench for the triangle gradient sensitivity core: directed and random requests checked against a local predictor.
module tb_fem_triangle_gradient_sensitivity_core;
  timeunit 1ns;
  timeprecision 1ps;
  import fem_tgs_pkg::*;

  localparam logic [1:0] OP_UNKNOWN = 2'd3;
  localparam int NODES = NODE_COUNT_DEF;
  // s_tdata field offsets, lowest bit first
  localparam int OFF_X  = 10;
  localparam int OFF_Y  = 42;
  localparam int OFF_DR = 74;
  localparam int OFF_DI = 106;
  localparam int OFF_AR = 138;
  localparam int OFF_AI = 170;
  localparam int OFF_VA = 202;
  localparam int OFF_VB = 212;
  localparam int OFF_VC = 222;
  localparam int RANDOM_REQUESTS = 1900;
  localparam int DRAIN_CYCLES = 800;
  localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] ACC_MIN = 64'sh8000_0000_0000_0000;

  typedef logic signed [191:0] wide_t;

  typedef struct packed {
    logic [9:0]         node;
    logic signed [63:0] re;
    logic signed [63:0] im;
    logic               status;
  } sens_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;

  fem_triangle_gradient_sensitivity_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #2 clk = ~clk;

  // predictor copy of the node store and accumulators
  logic signed [31:0] pos_x [NODES];
  logic signed [31:0] pos_y [NODES];
  logic signed [31:0] dir_re [NODES];
  logic signed [31:0] dir_im [NODES];
  logic signed [31:0] adj_re [NODES];
  logic signed [31:0] adj_im [NODES];
  logic signed [63:0] sens_re [NODES];
  logic signed [63:0] sens_im [NODES];
  bit                 loaded [NODES];
  int                 loaded_nodes [$];

  sens_result_t pending_results [$];
  int  error_count = 0;
  int  burst_left = 0;
  bit  sender_gaps = 1'b1;
  bit  receiver_stalls = 1'b1;
  bit  ready_phase = 1'b1;
  int  ready_run = 0;

  // truncating quotient of n / den, saturated to the accumulator range
  function automatic logic signed [63:0] sat_quotient(wide_t n, wide_t den);
    bit    neg;
    wide_t mag;
    wide_t q;
    neg = n < 0;
    mag = neg ? -n : n;
    q = $unsigned(mag) / $unsigned(den);
    if (neg) return (q > 64'h8000_0000_0000_0000) ? ACC_MIN : -q[63:0];
    return (q > 64'h7FFF_FFFF_FFFF_FFFF) ? ACC_MAX : q[63:0];
  endfunction

  function automatic logic signed [63:0] sat_accumulate(logic signed [63:0] acc,
                                                        logic signed [63:0] s);
    logic signed [65:0] t;
    t = acc + s;
    if (t > ACC_MAX) return ACC_MAX;
    if (t < ACC_MIN) return ACC_MIN;
    return t[63:0];
  endfunction

  // apply one triangle to the accumulators; return 1 when it is skipped
  function automatic bit apply_triangle(int va, int vb, int vc);
    int    v [3];
    int    t;
    wide_t x [3], y [3], px [3], py [3];
    wide_t d, den, uxr, uxi, uyr, uyi, vxr, vxi, vyr, vyi, nr, ni;
    logic signed [63:0] sr, si;
    v[0] = va; v[1] = vb; v[2] = vc;
    if (v[0] > v[1]) begin t = v[0]; v[0] = v[1]; v[1] = t; end
    if (v[1] > v[2]) begin t = v[1]; v[1] = v[2]; v[2] = t; end
    if (v[0] > v[1]) begin t = v[0]; v[0] = v[1]; v[1] = t; end
    if (v[2] >= NODES) return 1'b1;
    for (int j = 0; j < 3; j++) begin
      x[j] = wide_t'(pos_x[v[j]]);
      y[j] = wide_t'(pos_y[v[j]]);
    end
    px[0] = y[1] - y[2]; py[0] = x[2] - x[1];
    px[1] = y[2] - y[0]; py[1] = x[0] - x[2];
    px[2] = y[0] - y[1]; py[2] = x[1] - x[0];
    d = (x[1] - x[0]) * (y[2] - y[0]) - (y[1] - y[0]) * (x[2] - x[0]);
    if (d == 0) return 1'b1;
    den = (d < 0 ? -d : d) * 6;
    uxr = 0; uxi = 0; uyr = 0; uyi = 0; vxr = 0; vxi = 0; vyr = 0; vyi = 0;
    for (int j = 0; j < 3; j++) begin
      uxr += px[j] * wide_t'(dir_re[v[j]]);
      uxi += px[j] * wide_t'(dir_im[v[j]]);
      uyr += py[j] * wide_t'(dir_re[v[j]]);
      uyi += py[j] * wide_t'(dir_im[v[j]]);
      vxr += px[j] * wide_t'(adj_re[v[j]]);
      vxi += px[j] * wide_t'(adj_im[v[j]]);
      vyr += py[j] * wide_t'(adj_re[v[j]]);
      vyi += py[j] * wide_t'(adj_im[v[j]]);
    end
    nr = uxr * vxr - uxi * vxi + uyr * vyr - uyi * vyi;
    ni = uxr * vxi + uxi * vxr + uyr * vyi + uyi * vyr;
    sr = sat_quotient(nr, den);
    si = sat_quotient(ni, den);
    for (int j = 0; j < 3; j++) begin
      sens_re[v[j]] = sat_accumulate(sens_re[v[j]], sr);
      sens_im[v[j]] = sat_accumulate(sens_im[v[j]], si);
    end
    return 1'b0;
  endfunction

  // update the predictor for one accepted request and queue its result
  task automatic predict_sensitivity(logic [1:0] op, logic [S_TDATA_W-1:0] data);
    sens_result_t r;
    int node;
    node = int'(data[9:0]);
    r = '0;
    case (op)
      OP_LOAD: begin
        r.node = 10'(node);
        pos_x[node]  = data[OFF_X +: 32];
        pos_y[node]  = data[OFF_Y +: 32];
        dir_re[node] = data[OFF_DR +: 32];
        dir_im[node] = data[OFF_DI +: 32];
        adj_re[node] = data[OFF_AR +: 32];
        adj_im[node] = data[OFF_AI +: 32];
        if (!loaded[node]) begin
          loaded[node] = 1'b1;
          loaded_nodes.push_back(node);
        end
      end
      OP_ELEM: begin
        r.status = apply_triangle(data[OFF_VA +: 10], data[OFF_VB +: 10], data[OFF_VC +: 10]);
      end
      OP_READ: begin
        r.node = 10'(node);
        r.re = sens_re[node];
        r.im = sens_im[node];
      end
      default: ;
    endcase
    pending_results.push_back(r);
  endtask

  // drive one request, with random gaps between bursts
  task automatic send_request(logic [1:0] op, logic [S_TDATA_W-1:0] data);
    @(negedge clk);
    if (sender_gaps && burst_left <= 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    s_tvalid = 1'b1;
    s_tdata = data;
    s_tuser = op;
    do @(posedge clk); while (!s_tready);
    predict_sensitivity(op, data);
    burst_left--;
  endtask

  // mostly moderate Q16.16 values, sometimes full range or an extreme
  function automatic logic [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return 32'h7FFF_FFFF;
    if (sel == 1) return 32'h8000_0000;
    if (sel < 4) return $urandom;
    return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
  endfunction

  function automatic logic [S_TDATA_W-1:0] noise_data();
    logic [S_TDATA_W-1:0] d;
    for (int i = 0; i < S_TDATA_W; i += 32) d[i +: 32] = $urandom;
    return d;
  endfunction

  task automatic load_node(int node, logic [31:0] x, logic [31:0] y, logic [31:0] dr,
                           logic [31:0] di, logic [31:0] ar, logic [31:0] ai);
    logic [S_TDATA_W-1:0] d;
    d = noise_data();
    d[9:0] = 10'(node);
    d[OFF_X +: 32] = x;   d[OFF_Y +: 32] = y;
    d[OFF_DR +: 32] = dr; d[OFF_DI +: 32] = di;
    d[OFF_AR +: 32] = ar; d[OFF_AI +: 32] = ai;
    send_request(OP_LOAD, d);
  endtask

  task automatic run_triangle(int va, int vb, int vc);
    logic [S_TDATA_W-1:0] d;
    d = noise_data();
    d[OFF_VA +: 10] = 10'(va);
    d[OFF_VB +: 10] = 10'(vb);
    d[OFF_VC +: 10] = 10'(vc);
    send_request(OP_ELEM, d);
  endtask

  task automatic read_node(int node);
    logic [S_TDATA_W-1:0] d;
    d = noise_data();
    d[9:0] = 10'(node);
    send_request(OP_READ, d);
  endtask

  // unit triangle, a collinear point and two nodes with extreme values
  task automatic test_load_extremes();
    load_node(0, 32'h0, 32'h0, 32'h0001_0000, 32'h0000_8000, 32'h0002_0000, 32'hFFFF_0000);
    load_node(1, 32'h0001_0000, 32'h0, 32'hFFFF_8000, 32'h0001_0000, 32'h0001_0000, 32'h0);
    load_node(2, 32'h0, 32'h0001_0000, 32'h0003_0000, 32'h0, 32'h0, 32'h0004_0000);
    load_node(3, 32'h0002_0000, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
              32'h0001_0000);
    load_node(1023, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h8000_0000, 32'h7FFF_FFFF);
    load_node(512, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h8000_0000);
  endtask

  task automatic test_triangles();
    run_triangle(2, 0, 1);      // unsorted vertex order
    run_triangle(0, 1, 3);      // zero determinant
    run_triangle(1, 1, 2);      // repeated vertex
    run_triangle(0, 512, 1023); // huge area and values: saturation
    run_triangle(1023, 512, 0);
    run_triangle(2, 512, 1023);
  endtask

  task automatic test_reads();
    read_node(0);
    read_node(1);
    read_node(2);
    read_node(3);
    read_node(512);
    read_node(1023);
    read_node(700);             // never touched: zero sums
  endtask

  task automatic test_unknown_op();
    send_request(OP_UNKNOWN, noise_data());
    send_request(OP_UNKNOWN, ~noise_data());
  endtask

  task automatic test_random_traffic();
    int sel, a, b, c;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      // alternate stretches with and without idling
      if (n % 300 == 0) begin
        sender_gaps = (n / 300) % 3 != 1;
        receiver_stalls = (n / 300) % 3 != 2;
      end
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        if ($urandom_range(0, 1) || loaded_nodes.size() < 8) a = $urandom_range(0, NODES - 1);
        else a = loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
        load_node(a, pick_value(), pick_value(), pick_value(), pick_value(), pick_value(),
                  pick_value());
      end else if (sel < 70) begin
        a = loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
        b = loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
        c = ($urandom_range(0, 9) == 0) ? a
            : loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
        run_triangle(a, b, c);
      end else if (sel < 95) begin
        if ($urandom_range(0, 3) == 0) read_node($urandom_range(0, NODES - 1));
        else read_node(loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)]);
      end else begin
        send_request(OP_UNKNOWN, noise_data());
      end
    end
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  // receiver: alternate ready and stall runs of random length
  always @(negedge clk) begin
    if (!receiver_stalls) begin
      m_tready <= 1'b1;
    end else begin
      if (ready_run <= 0) begin
        ready_phase = ~ready_phase;
        ready_run = ready_phase ? $urandom_range(1, 8) : $urandom_range(1, 15);
      end
      ready_run--;
      m_tready <= ready_phase;
    end
  end

  // compare each delivered result with the oldest expectation
  always @(posedge clk) begin
    sens_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: node %0d", m_tdata[9:0]);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[9:0] !== want.node) begin
          $error("result_node: expected %0d, got %0d", want.node, m_tdata[9:0]);
          error_count++;
        end
        if (m_tdata[73:10] !== want.re) begin
          $error("sum_re: expected %0d, got %0d", want.re, $signed(m_tdata[73:10]));
          error_count++;
        end
        if (m_tdata[137:74] !== want.im) begin
          $error("sum_im: expected %0d, got %0d", want.im, $signed(m_tdata[137:74]));
          error_count++;
        end
        if (m_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tuser);
          error_count++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < NODES; i++) begin
      sens_re[i] = '0;
      sens_im[i] = '0;
      loaded[i] = 1'b0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_load_extremes();
    test_triangles();
    test_reads();
    test_unknown_op();
    test_random_traffic();
    // drain the results still in flight, then let the block settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
